### rtl/atsse_pkg.sv
// ----------------------------------------------------------------------------
// atsse_pkg: shared types for the table search and sort engine
// Operation and status codes, sequencer states and the compare result bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package atsse_pkg;

	localparam int OP_W    = 3;
	localparam int VALUE_W = 32;
	localparam int POS_W   = 7;
	localparam int FIDX_W  = 6;
	localparam int CNT_W   = 7;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR   = 3'd0,
		OP_APPEND  = 3'd1,
		OP_INSERT  = 3'd2,
		OP_DELETE  = 3'd3,
		OP_LSEARCH = 3'd4,
		OP_BSEARCH = 3'd5,
		OP_SORT    = 3'd6,
		OP_READ    = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_LIN_RD,
		S_LIN_CMP,
		S_BIN_RD,
		S_BIN_CMP,
		S_SORT_RDT,
		S_SORT_LDT,
		S_SORT_CMP,
		S_SORT_PUT,
		S_READ_RD,
		S_READ_CAP,
		S_DONE
	} state_t;

	typedef struct packed {
		logic eq;
		logic gt;
	} cmp_t;

endpackage

`default_nettype wire

### rtl/atsse_req_if.sv
// ----------------------------------------------------------------------------
// atsse_req_if: request channel
// Carries one table operation with its operand value and position.
// ----------------------------------------------------------------------------
`default_nettype none

interface atsse_req_if;
	import atsse_pkg::*;

	logic                       valid;
	logic                       ready;
	op_t                        op;
	logic signed [VALUE_W-1:0]  value;
	logic        [POS_W-1:0]    position;

	modport source (output valid, op, value, position, input ready);
	modport sink   (input valid, op, value, position, output ready);
endinterface

`default_nettype wire

### rtl/atsse_rsp_if.sv
// ----------------------------------------------------------------------------
// atsse_rsp_if: result channel
// Carries the status, search outcome, read data and entry count of one request.
// ----------------------------------------------------------------------------
`default_nettype none

interface atsse_rsp_if;
	import atsse_pkg::*;

	logic                       valid;
	logic                       ready;
	status_t                    status;
	logic                       hit;
	logic        [FIDX_W-1:0]   found_index;
	logic signed [VALUE_W-1:0]  read_value;
	logic        [CNT_W-1:0]    entry_count;

	modport source (output valid, status, hit, found_index, read_value, entry_count,
		input ready);
	modport sink   (input valid, status, hit, found_index, read_value, entry_count,
		output ready);
endinterface

`default_nettype wire

### rtl/atsse_cmp.sv
// ----------------------------------------------------------------------------
// atsse_cmp: shared word comparator
// Equality and signed greater-than of a table word against the held key.
// ----------------------------------------------------------------------------
`default_nettype none

module atsse_cmp #(
	parameter int WORD_BITS = 32
) (
	input  logic [WORD_BITS-1:0] a,
	input  logic [WORD_BITS-1:0] b,
	output atsse_pkg::cmp_t      res
);
	assign res.eq = (a == b);
	assign res.gt = ($signed(a) > $signed(b));
endmodule

`default_nettype wire

### rtl/array_table_search_sort_engine.sv
// ----------------------------------------------------------------------------
// array_table_search_sort_engine: bounded table with insert, delete, search, sort
// Insert and delete shift one entry per step, searches make one probe per step and sort
// moves entries one by one; the pace of all of them is set by the single table port,
// read and written once per step.
// One request at a time: ready is low from acceptance until the result reaches the
// output register. Reset empties the count and the output register, not the words.
// ----------------------------------------------------------------------------
`default_nettype none

module array_table_search_sort_engine #(
	parameter int DEPTH     = 64,
	parameter int WORD_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	atsse_req_if.sink   req,
	atsse_rsp_if.source rsp
);
	import atsse_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > POS_W) ? CW : POS_W;

	state_t state_q, state_d;

	logic [CW-1:0]        count_q;
	logic [CW-1:0]        idx_q;
	logic [CW-1:0]        j_q;
	logic [CW-1:0]        lo_q;
	logic [CW-1:0]        hx_q;
	logic [CW-1:0]        pos_q;
	op_t                  op_q;
	logic [WORD_BITS-1:0] key_q;

	status_t              status_q;
	logic                 hit_q;
	logic [CW-1:0]        fidx_q;
	logic [WORD_BITS-1:0] rd_q;

	logic                 out_valid_q;
	status_t              out_status_q;
	logic                 out_hit_q;
	logic [FIDX_W-1:0]    out_fidx_q;
	logic [VALUE_W-1:0]   out_rd_q;
	logic [CNT_W-1:0]     out_cnt_q;

	logic [WORD_BITS-1:0] mem [DEPTH];
	logic [WORD_BITS-1:0] rdata_q;
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [AW-1:0]        mem_raddr;
	logic [WORD_BITS-1:0] mem_wdata;

	logic                 req_ready;
	logic                 accept;
	logic                 load_out;
	logic [WORD_BITS-1:0] word_in;
	logic [PW-1:0]        pos_ext;
	logic [PW-1:0]        cnt_ext;
	logic                 full;
	logic                 empty;
	logic                 pos_le_cnt;
	logic                 pos_lt_cnt;
	status_t              accept_status;
	logic                 ins;
	logic                 shift_more;
	logic [CW-1:0]        idx_up;
	logic [CW-1:0]        idx_dn;
	logic [CW-1:0]        jm2;
	logic [CW:0]          mid_sum;
	logic [CW-1:0]        mid;
	cmp_t                 cmp;

	atsse_cmp #(.WORD_BITS(WORD_BITS)) u_cmp (
		.a   (rdata_q),
		.b   (key_q),
		.res (cmp)
	);

	assign req_ready  = (state_q == S_IDLE);
	assign accept     = req.valid && req_ready;
	assign word_in    = WORD_BITS'($signed(req.value));
	assign pos_ext    = PW'(req.position);
	assign cnt_ext    = PW'(count_q);
	assign full       = (count_q == CW'(DEPTH));
	assign empty      = (count_q == '0);
	assign pos_le_cnt = (pos_ext <= cnt_ext);
	assign pos_lt_cnt = (pos_ext < cnt_ext);

	assign ins        = (op_q == OP_INSERT);
	assign idx_up     = idx_q + CW'(1);
	assign idx_dn     = idx_q - CW'(1);
	assign jm2        = j_q - CW'(2);
	// Insert walks down from the old count to the slot; delete walks up from the slot.
	assign shift_more = ins ? (idx_q > pos_q) : (idx_up < count_q);
	// Probe the middle of the half-open range [lo, hx), rounding down.
	assign mid_sum    = {1'b0, lo_q} + {1'b0, hx_q} - (CW+1)'(1);
	assign mid        = mid_sum[CW:1];

	always_comb begin
		unique case (req.op)
			OP_APPEND:             accept_status = full ? ST_FULL : ST_OK;
			OP_INSERT:             accept_status = full ? ST_FULL :
				(!pos_le_cnt ? ST_RANGE : ST_OK);
			OP_DELETE, OP_READ:    accept_status = empty ? ST_EMPTY :
				(!pos_lt_cnt ? ST_RANGE : ST_OK);
			OP_LSEARCH, OP_BSEARCH: accept_status = empty ? ST_EMPTY : ST_OK;
			OP_CLEAR, OP_SORT:     accept_status = ST_OK;
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					unique case (req.op)
						OP_CLEAR, OP_APPEND: state_d = S_DONE;
						OP_INSERT:  state_d = (full || !pos_le_cnt) ? S_DONE : S_SHIFT_RD;
						OP_DELETE:  state_d = (empty || !pos_lt_cnt) ? S_DONE : S_SHIFT_RD;
						OP_LSEARCH: state_d = empty ? S_DONE : S_LIN_RD;
						OP_BSEARCH: state_d = empty ? S_DONE : S_BIN_RD;
						OP_SORT:    state_d = (count_q < CW'(2)) ? S_DONE : S_SORT_RDT;
						OP_READ:    state_d = (empty || !pos_lt_cnt) ? S_DONE : S_READ_RD;
					endcase
				end
			end
			S_SHIFT_RD: state_d = shift_more ? S_SHIFT_WR : S_DONE;
			S_SHIFT_WR: state_d = S_SHIFT_RD;
			S_LIN_RD:   state_d = S_LIN_CMP;
			S_LIN_CMP:  state_d = (cmp.eq || idx_up == count_q) ? S_DONE : S_LIN_RD;
			S_BIN_RD:   state_d = (lo_q < hx_q) ? S_BIN_CMP : S_DONE;
			S_BIN_CMP:  state_d = cmp.eq ? S_DONE : S_BIN_RD;
			S_SORT_RDT: state_d = S_SORT_LDT;
			S_SORT_LDT: state_d = S_SORT_CMP;
			S_SORT_CMP: state_d = (!cmp.gt || j_q == CW'(1)) ? S_SORT_PUT : S_SORT_CMP;
			S_SORT_PUT: state_d = (idx_up < count_q) ? S_SORT_RDT : S_DONE;
			S_READ_RD:  state_d = S_READ_CAP;
			S_READ_CAP: state_d = S_DONE;
			S_DONE:     state_d = (!out_valid_q || rsp.ready) ? S_IDLE : S_DONE;
			default:    state_d = S_IDLE;
		endcase
	end

	// Table port control and result hand-off.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q[AW-1:0];
		mem_wdata = rdata_q;
		mem_raddr = idx_q[AW-1:0];
		load_out  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept && req.op == OP_APPEND && !full) begin
					mem_we    = 1'b1;
					mem_waddr = count_q[AW-1:0];
					mem_wdata = word_in;
				end
			end
			S_SHIFT_RD: begin
				mem_raddr = ins ? idx_dn[AW-1:0] : idx_up[AW-1:0];
				if (ins && !shift_more) begin
					mem_we    = 1'b1;
					mem_waddr = pos_q[AW-1:0];
					mem_wdata = key_q;
				end
			end
			S_SHIFT_WR: mem_we = 1'b1;
			S_BIN_RD:   mem_raddr = mid[AW-1:0];
			S_SORT_LDT: mem_raddr = idx_dn[AW-1:0];
			S_SORT_CMP: begin
				mem_raddr = jm2[AW-1:0];
				if (cmp.gt) begin
					mem_we    = 1'b1;
					mem_waddr = j_q[AW-1:0];
				end
			end
			S_SORT_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = j_q[AW-1:0];
				mem_wdata = key_q;
			end
			S_READ_RD:  mem_raddr = pos_q[AW-1:0];
			S_DONE:     load_out  = !out_valid_q || rsp.ready;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && req.op == OP_CLEAR) begin
				count_q <= '0;
			end else if (accept && req.op == OP_APPEND && !full) begin
				count_q <= count_q + CW'(1);
			end else if (state_q == S_SHIFT_RD && !shift_more) begin
				count_q <= ins ? count_q + CW'(1) : count_q - CW'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q     <= req.op;
					key_q    <= word_in;
					pos_q    <= CW'(req.position);
					status_q <= accept_status;
					hit_q    <= 1'b0;
					fidx_q   <= '0;
					rd_q     <= '0;
					lo_q     <= '0;
					hx_q     <= count_q;
					unique case (req.op)
						OP_INSERT: idx_q <= count_q;
						OP_DELETE: idx_q <= CW'(req.position);
						OP_SORT:   idx_q <= CW'(1);
						default:   idx_q <= '0;
					endcase
				end
			end
			S_SHIFT_WR: idx_q <= ins ? idx_dn : idx_up;
			S_LIN_CMP: begin
				if (cmp.eq) begin
					hit_q  <= 1'b1;
					fidx_q <= idx_q;
				end else begin
					idx_q <= idx_up;
				end
			end
			S_BIN_RD: idx_q <= mid;
			S_BIN_CMP: begin
				if (cmp.eq) begin
					hit_q  <= 1'b1;
					fidx_q <= idx_q;
				end else if (cmp.gt) begin
					hx_q <= idx_q;
				end else begin
					lo_q <= idx_up;
				end
			end
			S_SORT_LDT: begin
				key_q <= rdata_q;
				j_q   <= idx_q;
			end
			S_SORT_CMP: begin
				if (cmp.gt) begin
					j_q <= j_q - CW'(1);
				end
			end
			S_SORT_PUT: idx_q <= idx_up;
			S_READ_CAP: rd_q  <= rdata_q;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_status_q <= status_q;
			out_hit_q    <= hit_q;
			out_fidx_q   <= FIDX_W'(fidx_q);
			out_rd_q     <= VALUE_W'($signed(rd_q));
			out_cnt_q    <= CNT_W'(count_q);
		end
	end

	assign req.ready       = req_ready;
	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.hit         = out_hit_q;
	assign rsp.found_index = out_fidx_q;
	assign rsp.read_value  = out_rd_q;
	assign rsp.entry_count = out_cnt_q;

endmodule

`default_nettype wire

### rtl/atsse_chk.sv
// ----------------------------------------------------------------------------
// atsse_chk: port-level checks for the table search and sort engine
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module atsse_chk #(
	parameter int DEPTH = 64
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             req_valid,
	input logic                             req_ready,
	input logic                             rsp_valid,
	input atsse_pkg::status_t               rsp_status,
	input logic                             rsp_hit,
	input logic [atsse_pkg::FIDX_W-1:0]     rsp_found_index,
	input logic [atsse_pkg::VALUE_W-1:0]    rsp_read_value,
	input logic [atsse_pkg::CNT_W-1:0]      rsp_entry_count
);
	import atsse_pkg::*;

	// A taken request keeps the engine busy for at least the following cycle.
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken but engine ready again at once");

	a_hit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_hit |-> rsp_status == ST_OK)
		else $error("hit reported with a failing status");

	a_miss_index: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_hit |-> rsp_found_index == '0)
		else $error("found index nonzero without a hit");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_FULL |-> rsp_entry_count == CNT_W'(DEPTH))
		else $error("full status while the table is not full");

	a_fail_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ST_OK |-> rsp_read_value == '0)
		else $error("read data returned with a failing status");

endmodule

bind array_table_search_sort_engine atsse_chk #(.DEPTH(DEPTH)) u_atsse_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_status      (rsp.status),
	.rsp_hit         (rsp.hit),
	.rsp_found_index (rsp.found_index),
	.rsp_read_value  (rsp.read_value),
	.rsp_entry_count (rsp.entry_count)
);

`default_nettype wire

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the table search and sort engine
// Runs a short table of directed requests, then episodes of random requests
// that fill, shuffle, sort and search the table. A software copy of the table
// predicts the results that the directed table does not give, and each result is compared field by field in order.
// Both channels idle and stall at random, with one long result hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	import atsse_pkg::*;

	localparam int DEPTH        = 64;
	localparam int N_DIRECTED   = 25;
	localparam int RANDOM_ITEMS = 1750;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_CYCLES = 100;
	localparam int HOLD_AFTER   = 200;
	localparam int HOLD_CYCLES  = 400;

	typedef struct packed {
		status_t     status;
		logic        hit;
		logic [5:0]  found_index;
		logic [31:0] read_value;
		logic [6:0]  entry_count;
	} result_t;

	typedef struct {
		op_t         op;
		logic [31:0] value;
		logic [6:0]  position;
		bit          typed;
		result_t     exp;
	} dir_row_t;

	localparam result_t NO_RESULT = '0;

	logic clk;
	logic arst_n;

	atsse_req_if req_ch ();
	atsse_rsp_if rsp_ch ();

	array_table_search_sort_engine #(
		.DEPTH    (DEPTH),
		.WORD_BITS(32)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// Software copy of the table.
	logic signed [31:0] tbl_words [DEPTH];
	int                 tbl_count;

	result_t  pending_results [$];
	dir_row_t dir_rows [N_DIRECTED];
	int       req_accepted;
	int       burst_left;
	int       fail_cnt;
	int       cycle_cnt;

	initial clk = 1'b0;

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic result_t apply_table_op(op_t op, logic [31:0] value,
		logic [6:0] pos);
		result_t            r;
		int                 lo, hi, mid, j;
		logic signed [31:0] key, t;
		r = NO_RESULT;
		r.status = ST_OK;
		key = value;
		case (op)
			OP_CLEAR: tbl_count = 0;
			OP_APPEND: begin
				if (tbl_count >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					tbl_words[tbl_count] = key;
					tbl_count++;
				end
			end
			OP_INSERT: begin
				if (tbl_count >= DEPTH) begin
					r.status = ST_FULL;
				end else if (int'(pos) > tbl_count) begin
					r.status = ST_RANGE;
				end else begin
					for (j = tbl_count; j > int'(pos); j--)
						tbl_words[j] = tbl_words[j-1];
					tbl_words[pos] = key;
					tbl_count++;
				end
			end
			OP_DELETE: begin
				if (tbl_count == 0) begin
					r.status = ST_EMPTY;
				end else if (int'(pos) >= tbl_count) begin
					r.status = ST_RANGE;
				end else begin
					for (j = int'(pos); j + 1 < tbl_count; j++)
						tbl_words[j] = tbl_words[j+1];
					tbl_count--;
				end
			end
			OP_LSEARCH: begin
				if (tbl_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					for (j = 0; j < tbl_count; j++) begin
						if (tbl_words[j] == key) begin
							r.hit = 1'b1;
							r.found_index = 6'(j);
							break;
						end
					end
				end
			end
			OP_BSEARCH: begin
				if (tbl_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					// Probes follow the halving order even when the table is not sorted.
					lo = 0;
					hi = tbl_count - 1;
					while (lo <= hi) begin
						mid = (lo + hi) / 2;
						if (tbl_words[mid] == key) begin
							r.hit = 1'b1;
							r.found_index = 6'(mid);
							break;
						end
						if (key < tbl_words[mid])
							hi = mid - 1;
						else
							lo = mid + 1;
					end
				end
			end
			OP_SORT: begin
				for (j = 1; j < tbl_count; j++) begin
					t = tbl_words[j];
					lo = j;
					while (lo > 0 && tbl_words[lo-1] > t) begin
						tbl_words[lo] = tbl_words[lo-1];
						lo--;
					end
					tbl_words[lo] = t;
				end
			end
			OP_READ: begin
				if (tbl_count == 0)
					r.status = ST_EMPTY;
				else if (int'(pos) >= tbl_count)
					r.status = ST_RANGE;
				else
					r.read_value = tbl_words[pos];
			end
		endcase
		r.entry_count = 7'(tbl_count);
		return r;
	endfunction

	// Sends one request in bursts and records what it should produce.
	task automatic issue(op_t op, logic [31:0] value, logic [6:0] pos, bit typed,
		result_t exp);
		int      gap;
		result_t pred;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		req_ch.valid    <= 1'b1;
		req_ch.op       <= op;
		req_ch.value    <= value;
		req_ch.position <= pos;
		do @(posedge clk); while (!req_ch.ready);
		burst_left--;
		pred = apply_table_op(op, value, pos);
		pending_results.push_back(typed ? exp : pred);
		req_accepted++;
	endtask

	function automatic logic [31:0] pick_value(bit as_key);
		if (as_key && tbl_count > 0 && $urandom_range(0, 2) != 0)
			return tbl_words[$urandom_range(0, tbl_count - 1)];
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2, 3, 4, 5: return 32'(int'($urandom_range(0, 12)) - 6);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [6:0] pick_pos(op_t op);
		int top;
		top = (op == OP_INSERT) ? tbl_count : tbl_count - 1;
		case ($urandom_range(0, 9))
			0: return 7'($urandom_range(0, 127));
			1: return 7'(tbl_count);
			default: return (top < 0) ? 7'd0 : 7'($urandom_range(0, top));
		endcase
	endfunction

	function automatic op_t pick_op(bit big, int cap);
		int  r;
		op_t op;
		r = $urandom_range(0, 99);
		if (r < 2)       op = OP_CLEAR;
		else if (r < 22) op = OP_APPEND;
		else if (r < 40) op = OP_INSERT;
		else if (r < 55) op = OP_DELETE;
		else if (r < 68) op = OP_LSEARCH;
		else if (r < 80) op = OP_BSEARCH;
		else if (r < 88) op = OP_SORT;
		else             op = OP_READ;
		// Keep the table near its target size; in a big episode some appends and inserts still reach a full table.
		if ((op == OP_APPEND || op == OP_INSERT) && tbl_count >= cap
				&& !(big && $urandom_range(0, 2) == 0))
			op = OP_DELETE;
		// Sorting a full table is slow, so it stays rare there.
		if (big && op == OP_SORT && $urandom_range(0, 3) != 0)
			op = OP_BSEARCH;
		return op;
	endfunction

	// Result checker.
	always @(posedge clk) begin
		result_t exp;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("result received with no request outstanding");
				fail_cnt++;
			end else begin
				exp = pending_results.pop_front();
				if (rsp_ch.status !== exp.status) begin
					$error("status: expected %0d, got %0d", exp.status, rsp_ch.status);
					fail_cnt++;
				end
				if (rsp_ch.hit !== exp.hit) begin
					$error("hit: expected %0d, got %0d", exp.hit, rsp_ch.hit);
					fail_cnt++;
				end
				if (rsp_ch.found_index !== exp.found_index) begin
					$error("found_index: expected %0d, got %0d", exp.found_index,
						rsp_ch.found_index);
					fail_cnt++;
				end
				if (rsp_ch.read_value !== exp.read_value) begin
					$error("read_value: expected %0d, got %0d",
						$signed(exp.read_value), rsp_ch.read_value);
					fail_cnt++;
				end
				if (rsp_ch.entry_count !== exp.entry_count) begin
					$error("entry_count: expected %0d, got %0d", exp.entry_count,
						rsp_ch.entry_count);
					fail_cnt++;
				end
			end
		end
	end

	// Result side: changing stall patterns and one long hold-off.
	initial begin
		int mode, mode_left, tick;
		bit held_off;
		mode_left = 0;
		tick = 0;
		held_off = 1'b0;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held_off && req_accepted >= HOLD_AFTER) begin
				held_off = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 150);
			end
			mode_left--;
			tick++;
			case (mode)
				0: rsp_ch.ready <= 1'b1;
				1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
				2: rsp_ch.ready <= (tick % 3 == 0);
				default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Request side.
	initial begin
		int  episode, cap, len;
		bit  big;
		op_t op;
		cycle_cnt = 0;
		fail_cnt = 0;
		req_accepted = 0;
		burst_left = 0;
		tbl_count = 0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.op = OP_CLEAR;
		req_ch.value = '0;
		req_ch.position = '0;

		dir_rows = '{
			'{OP_READ,    32'd0,         7'd0,   1'b1, '{ST_EMPTY, 1'b0, 6'd0, 32'd0, 7'd0}},
			'{OP_DELETE,  32'd0,         7'd0,   1'b1, '{ST_EMPTY, 1'b0, 6'd0, 32'd0, 7'd0}},
			'{OP_LSEARCH, 32'd5,         7'd0,   1'b1, '{ST_EMPTY, 1'b0, 6'd0, 32'd0, 7'd0}},
			'{OP_BSEARCH, 32'd5,         7'd0,   1'b1, '{ST_EMPTY, 1'b0, 6'd0, 32'd0, 7'd0}},
			'{OP_SORT,    32'd0,         7'd0,   1'b1, '{ST_OK,    1'b0, 6'd0, 32'd0, 7'd0}},
			'{OP_CLEAR,   32'd0,         7'd0,   1'b1, '{ST_OK,    1'b0, 6'd0, 32'd0, 7'd0}},
			'{OP_APPEND,  32'h7FFF_FFFF, 7'd0,   1'b1, '{ST_OK,    1'b0, 6'd0, 32'd0, 7'd1}},
			'{OP_APPEND,  32'h8000_0000, 7'd0,   1'b1, '{ST_OK,    1'b0, 6'd0, 32'd0, 7'd2}},
			'{OP_INSERT,  32'd0,         7'd3,   1'b1, '{ST_RANGE, 1'b0, 6'd0, 32'd0, 7'd2}},
			'{OP_INSERT,  32'hFFFF_FFFF, 7'd2,   1'b0, NO_RESULT},
			'{OP_INSERT,  32'd123,       7'd0,   1'b0, NO_RESULT},
			'{OP_READ,    32'd0,         7'd64,  1'b1, '{ST_RANGE, 1'b0, 6'd0, 32'd0, 7'd4}},
			'{OP_READ,    32'd0,         7'd127, 1'b1, '{ST_RANGE, 1'b0, 6'd0, 32'd0, 7'd4}},
			'{OP_READ,    32'd0,         7'd1,   1'b0, NO_RESULT},
			'{OP_LSEARCH, 32'h8000_0000, 7'd0,   1'b0, NO_RESULT},
			'{OP_LSEARCH, 32'd77,        7'd0,   1'b0, NO_RESULT},
			'{OP_BSEARCH, 32'd123,       7'd0,   1'b0, NO_RESULT},
			'{OP_SORT,    32'd0,         7'd0,   1'b0, NO_RESULT},
			'{OP_BSEARCH, 32'hFFFF_FFFF, 7'd0,   1'b0, NO_RESULT},
			'{OP_BSEARCH, 32'h7FFF_FFFF, 7'd0,   1'b0, NO_RESULT},
			'{OP_DELETE,  32'd0,         7'd4,   1'b1, '{ST_RANGE, 1'b0, 6'd0, 32'd0, 7'd4}},
			'{OP_DELETE,  32'd0,         7'd3,   1'b0, NO_RESULT},
			'{OP_DELETE,  32'd0,         7'd0,   1'b0, NO_RESULT},
			'{OP_READ,    32'd0,         7'd0,   1'b0, NO_RESULT},
			'{OP_CLEAR,   32'd0,         7'd0,   1'b1, '{ST_OK,    1'b0, 6'd0, 32'd0, 7'd0}}
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			issue(dir_rows[i].op, dir_rows[i].value, dir_rows[i].position,
				dir_rows[i].typed, dir_rows[i].exp);

		// Most episodes start from an empty table, usually small; the first one fills it.
		episode = 0;
		while (req_accepted < N_DIRECTED + RANDOM_ITEMS) begin
			big = (episode == 0) || ($urandom_range(0, 29) == 0);
			cap = big ? DEPTH : $urandom_range(1, 12);
			if (big || $urandom_range(0, 4) != 0)
				issue(OP_CLEAR, pick_value(1'b0), pick_pos(OP_CLEAR), 1'b0, NO_RESULT);
			if (big) begin
				repeat (DEPTH)
					issue(OP_APPEND, pick_value(1'b0), pick_pos(OP_APPEND), 1'b0, NO_RESULT);
			end
			len = big ? 80 : $urandom_range(8, 40);
			repeat (len) begin
				op = pick_op(big, cap);
				issue(op, pick_value(op == OP_LSEARCH || op == OP_BSEARCH), pick_pos(op),
					1'b0, NO_RESULT);
			end
			episode++;
		end
		req_ch.valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_cnt == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire

### filelist.f
rtl/atsse_pkg.sv
rtl/atsse_req_if.sv
rtl/atsse_rsp_if.sv
rtl/atsse_cmp.sv
rtl/array_table_search_sort_engine.sv
rtl/atsse_chk.sv
tb/tb_top.sv
